FILE: rtl/lrgd_pkg.sv
// Package with shared types, constants and fixed-point helpers for the regression block.
`default_nettype none
package lrgd_pkg;

	localparam int MAX_ROWS     = 256;
	localparam int MAX_FEATURES = 7;
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int FEAT_DEPTH   = MAX_ROWS * MAX_FEATURES;
	localparam int FADDR_W      = $clog2(FEAT_DEPTH);
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	localparam logic [1:0] REQ_LOAD_FEATURE = 2'd0;
	localparam logic [1:0] REQ_LOAD_TARGET  = 2'd1;
	localparam logic [1:0] REQ_START        = 2'd2;

	localparam logic [2:0] CFG_ROW_COUNT       = 3'd0;
	localparam logic [2:0] CFG_FEATURE_COUNT   = 3'd1;
	localparam logic [2:0] CFG_LEARNING_RATE   = 3'd2;
	localparam logic [2:0] CFG_ITERATION_COUNT = 3'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         row_index;
		logic [2:0]         feature_index;
		logic signed [31:0] sample_value;
	} req_t;

	typedef struct packed {
		logic [2:0]         weight_index;
		logic signed [31:0] weight_value;
		logic [31:0]        final_error;
		logic               saturated;
		logic               last_weight;
	} res_t;

	typedef struct packed {
		logic                     fen;
		logic                     ten;
		logic [FADDR_W-1:0]       faddr;
		logic [ROW_W-1:0]         taddr;
		logic signed [31:0]       data;
	} store_wr_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ITER_INIT, S_PRED_RD, S_PRED_MUL, S_PRED_ACC, S_ERR,
		S_SQ_MUL, S_SQ_ACC, S_GRAD_MUL, S_GRAD_ACC, S_UPD_GO, S_UPD_WAIT,
		S_UPD_MUL, S_UPD_WB, S_FIN_GO, S_FIN_WAIT, S_EMIT
	} state_t;

	// round Q32.32 (or Q16.32) to Q16.16: add half, floor shift
	function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
		logic signed [63:0] t;
		t = x + 64'sd32768;
		return t >>> 16;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] x);
		return !((&x[63:31]) || !(|x[63:31]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (!ovf32(x)) return x[31:0];
		return x[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lrgd_div.sv
// Restoring divider: 64-bit dividend by 9-bit divisor, one quotient bit per cycle.
`default_nettype none
module lrgd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [8:0]  divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [8:0]  rem_q;
	logic [8:0]  dvs_q;
	logic [63:0] quo_q;
	logic [9:0]  r2;
	logic [9:0]  rsub;
	logic        ge;

	always_comb begin
		r2   = {rem_q, quo_q[63]};
		ge   = r2 >= {1'b0, dvs_q};
		rsub = r2 - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? rsub[8:0] : r2[8:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/lrgd_store.sv
// Feature and target memories with one write port and registered reads.
`default_nettype none
module lrgd_store (
	input  wire logic                              clk,
	input  wire lrgd_pkg::store_wr_t               wr,
	input  wire logic [lrgd_pkg::FADDR_W-1:0]      rd_faddr,
	input  wire logic [lrgd_pkg::ROW_W-1:0]        rd_taddr,
	output logic signed [31:0]                     rd_fdata,
	output logic signed [31:0]                     rd_tdata
);
	logic signed [31:0] fmem [lrgd_pkg::FEAT_DEPTH];
	logic signed [31:0] tmem [lrgd_pkg::MAX_ROWS];

	always_ff @(posedge clk) begin
		if (wr.fen) fmem[wr.faddr] <= wr.data;
		rd_fdata <= fmem[rd_faddr];
	end

	always_ff @(posedge clk) begin
		if (wr.ten) tmem[wr.taddr] <= wr.data;
		rd_tdata <= tmem[rd_taddr];
	end
endmodule
`default_nettype wire

FILE: rtl/linear_regression_gradient_descent.sv
// Top level: batch gradient-descent linear regression sequencer around the sample memories.
//
//   channel   signals                          handshake
//   request   start, req (req_t), busy         taken when start && !busy
//   result    result_valid, result (res_t)     valid per weight, never stalled
//   config    cfg_we, cfg_index, cfg_data      taken when cfg_we
//
// Loads are taken back to back. A run goes over cols = features + 1 columns, bias first:
// per row, a read, multiply and accumulate per column for the prediction, then the error and
// its square, then a multiply and accumulate per column for the gradient; per weight, the
// serial divider and the 16-step rate multiply, then the write-back.
// Reset clears control and configuration; the sample memories hold garbage until loaded.
// Results cannot be stalled: weights stream out one per cycle, bias first.
`default_nettype none
module linear_regression_gradient_descent (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire lrgd_pkg::req_t  req,
	output logic                 busy,
	output logic                 result_valid,
	output lrgd_pkg::res_t       result,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [19:0]     cfg_data
);
	lrgd_pkg::state_t state_q, state_d;

	logic [8:0]  rc_q;
	logic [2:0]  fc_q;
	logic [15:0] lr_q;
	logic [19:0] ic_q;

	logic [8:0]  rows_q;
	logic [2:0]  nf_q;
	logic [19:0] iters_q;
	logic [19:0] it_q;
	logic [7:0]  r_q;
	logic [2:0]  c_q;
	logic [3:0]  k_q;
	logic        sat_q;

	logic signed [31:0] w_q [8];
	logic signed [63:0] g_q [8];
	logic signed [31:0] xrow_q [8];
	logic signed [63:0] pred_q;
	logic signed [31:0] t_q;
	logic signed [31:0] e_q;
	logic [63:0]        sse_q;
	logic signed [63:0] avg_q;
	logic [63:0]        acc_q;
	logic [31:0]        err_q;
	logic signed [63:0] prod_s1;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic               div_start, div_done;
	logic [63:0]        div_dividend, div_quot;
	lrgd_pkg::store_wr_t wr;
	logic [lrgd_pkg::FADDR_W-1:0] rd_faddr;
	logic signed [31:0] rd_fdata, rd_tdata;

	logic accept, row_last, it_last, col_last;
	logic signed [63:0] p64, diff, wdiff, abs_g;
	logic [64:0] sse_sum;

	assign accept   = start && !busy;
	assign col_last = c_q == nf_q;
	assign row_last = {1'b0, r_q} == rows_q - 9'd1;
	assign it_last  = it_q == iters_q - 20'd1;
	assign mul_p    = mul_a * mul_b;

	lrgd_store u_store (
		.clk(clk), .wr(wr), .rd_faddr(rd_faddr), .rd_taddr(r_q),
		.rd_fdata(rd_fdata), .rd_tdata(rd_tdata)
	);

	lrgd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(rows_q), .done(div_done), .quotient(div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrgd_pkg::S_IDLE:
				if (accept && req.req_type == lrgd_pkg::REQ_START) state_d = lrgd_pkg::S_ITER_INIT;
			lrgd_pkg::S_ITER_INIT: state_d = lrgd_pkg::S_PRED_RD;
			lrgd_pkg::S_PRED_RD:   state_d = lrgd_pkg::S_PRED_MUL;
			lrgd_pkg::S_PRED_MUL:  state_d = lrgd_pkg::S_PRED_ACC;
			lrgd_pkg::S_PRED_ACC:
				state_d = col_last ? lrgd_pkg::S_ERR : lrgd_pkg::S_PRED_RD;
			lrgd_pkg::S_ERR:       state_d = lrgd_pkg::S_SQ_MUL;
			lrgd_pkg::S_SQ_MUL:    state_d = lrgd_pkg::S_SQ_ACC;
			lrgd_pkg::S_SQ_ACC:    state_d = lrgd_pkg::S_GRAD_MUL;
			lrgd_pkg::S_GRAD_MUL:  state_d = lrgd_pkg::S_GRAD_ACC;
			lrgd_pkg::S_GRAD_ACC:
				if (!col_last) state_d = lrgd_pkg::S_GRAD_MUL;
				else state_d = row_last ? lrgd_pkg::S_UPD_GO : lrgd_pkg::S_PRED_RD;
			lrgd_pkg::S_UPD_GO:    state_d = lrgd_pkg::S_UPD_WAIT;
			lrgd_pkg::S_UPD_WAIT:
				if (div_done) state_d = lrgd_pkg::S_UPD_MUL;
			lrgd_pkg::S_UPD_MUL:
				if (k_q == 4'd15) state_d = lrgd_pkg::S_UPD_WB;
			lrgd_pkg::S_UPD_WB:
				if (!col_last) state_d = lrgd_pkg::S_UPD_GO;
				else state_d = it_last ? lrgd_pkg::S_FIN_GO : lrgd_pkg::S_ITER_INIT;
			lrgd_pkg::S_FIN_GO:    state_d = lrgd_pkg::S_FIN_WAIT;
			lrgd_pkg::S_FIN_WAIT:
				if (div_done) state_d = lrgd_pkg::S_EMIT;
			lrgd_pkg::S_EMIT:
				if (col_last) state_d = lrgd_pkg::S_IDLE;
			default: state_d = lrgd_pkg::S_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		abs_g        = g_q[c_q][63] ? -g_q[c_q] : g_q[c_q];
		div_start    = state_q == lrgd_pkg::S_UPD_GO || state_q == lrgd_pkg::S_FIN_GO;
		div_dividend = (state_q == lrgd_pkg::S_UPD_GO) ? abs_g : (sse_q >> 17);
		rd_faddr     = lrgd_pkg::FADDR_W'({r_q, 3'b000}) - lrgd_pkg::FADDR_W'(r_q)
		             + lrgd_pkg::FADDR_W'(c_q) - lrgd_pkg::FADDR_W'(1);
		mul_a        = w_q[c_q];
		mul_b        = (c_q == 3'd0) ? lrgd_pkg::ONE_Q16 : rd_fdata;
		unique case (state_q)
			lrgd_pkg::S_SQ_MUL:   begin mul_a = e_q; mul_b = e_q; end
			lrgd_pkg::S_GRAD_MUL: begin mul_a = e_q; mul_b = xrow_q[c_q]; end
			default: ;
		endcase
		busy         = state_q != lrgd_pkg::S_IDLE;
		result_valid = state_q == lrgd_pkg::S_EMIT;
		result.weight_index = c_q;
		result.weight_value = w_q[c_q];
		result.final_error  = err_q;
		result.saturated    = sat_q;
		result.last_weight  = col_last;
		wr.fen   = accept && req.req_type == lrgd_pkg::REQ_LOAD_FEATURE
		         && req.feature_index < 3'(lrgd_pkg::MAX_FEATURES);
		wr.ten   = accept && req.req_type == lrgd_pkg::REQ_LOAD_TARGET;
		wr.faddr = lrgd_pkg::FADDR_W'({req.row_index, 3'b000})
		         - lrgd_pkg::FADDR_W'(req.row_index) + lrgd_pkg::FADDR_W'(req.feature_index);
		wr.taddr = req.row_index;
		wr.data  = req.sample_value;
	end

	always_comb begin
		p64     = 64'(lrgd_pkg::sat32(pred_q));
		diff    = p64 - 64'(t_q);
		sse_sum = {1'b0, sse_q} + {1'b0, prod_s1};
		wdiff   = 64'(w_q[c_q]) - lrgd_pkg::round_q16(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrgd_pkg::S_IDLE;
			rc_q    <= 9'd1;
			fc_q    <= 3'd1;
			lr_q    <= 16'd655;
			ic_q    <= 20'd1000;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					lrgd_pkg::CFG_ROW_COUNT:       rc_q <= cfg_data[8:0];
					lrgd_pkg::CFG_FEATURE_COUNT:   fc_q <= cfg_data[2:0];
					lrgd_pkg::CFG_LEARNING_RATE:   lr_q <= cfg_data[15:0];
					lrgd_pkg::CFG_ITERATION_COUNT: ic_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lrgd_pkg::S_IDLE: begin
				rows_q  <= (rc_q == 9'd0) ? 9'd1 :
				           (rc_q > 9'(lrgd_pkg::MAX_ROWS)) ? 9'(lrgd_pkg::MAX_ROWS) : rc_q;
				nf_q    <= (fc_q == 3'd0) ? 3'd1 :
				           (fc_q > 3'(lrgd_pkg::MAX_FEATURES)) ? 3'(lrgd_pkg::MAX_FEATURES) : fc_q;
				iters_q <= (ic_q == 20'd0) ? 20'd1 : ic_q;
				sat_q   <= 1'b0;
				it_q    <= '0;
				c_q     <= '0;
				for (int i = 0; i < 8; i++) w_q[i] <= '0;
			end
			lrgd_pkg::S_ITER_INIT: begin
				for (int i = 0; i < 8; i++) g_q[i] <= '0;
				sse_q  <= '0;
				pred_q <= '0;
				r_q    <= '0;
				c_q    <= '0;
			end
			lrgd_pkg::S_PRED_MUL: begin
				xrow_q[c_q] <= mul_b;
				prod_s1     <= mul_p;
				if (c_q == 3'd0) t_q <= rd_tdata;
			end
			lrgd_pkg::S_PRED_ACC: begin
				pred_q <= pred_q + lrgd_pkg::round_q16(prod_s1);
				c_q    <= col_last ? 3'd0 : c_q + 3'd1;
			end
			lrgd_pkg::S_ERR: begin
				e_q <= lrgd_pkg::sat32(diff);
				if (lrgd_pkg::ovf32(pred_q) || lrgd_pkg::ovf32(diff)) sat_q <= 1'b1;
			end
			lrgd_pkg::S_SQ_MUL, lrgd_pkg::S_GRAD_MUL: prod_s1 <= mul_p;
			lrgd_pkg::S_SQ_ACC: begin
				// saturate the sum at all ones
				if (sse_sum[64]) begin
					sse_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sse_q <= sse_sum[63:0];
				end
			end
			lrgd_pkg::S_GRAD_ACC: begin
				g_q[c_q] <= g_q[c_q] + lrgd_pkg::round_q16(prod_s1);
				if (col_last) begin
					c_q    <= '0;
					pred_q <= '0;
					r_q    <= row_last ? 8'd0 : r_q + 8'd1;
				end else begin
					c_q <= c_q + 3'd1;
				end
			end
			lrgd_pkg::S_UPD_WAIT: begin
				avg_q <= g_q[c_q][63] ? -div_quot : div_quot;
				acc_q <= '0;
				k_q   <= '0;
			end
			lrgd_pkg::S_UPD_MUL: begin
				if (lr_q[k_q]) acc_q <= acc_q + (avg_q << k_q);
				k_q <= k_q + 4'd1;
			end
			lrgd_pkg::S_UPD_WB: begin
				w_q[c_q] <= lrgd_pkg::sat32(wdiff);
				if (lrgd_pkg::ovf32(wdiff)) sat_q <= 1'b1;
				if (col_last) begin
					c_q  <= '0;
					it_q <= it_q + 20'd1;
				end else begin
					c_q <= c_q + 3'd1;
				end
			end
			lrgd_pkg::S_FIN_WAIT: begin
				if (div_done) begin
					c_q <= '0;
					if (|div_quot[63:32]) begin
						err_q <= '1;
						sat_q <= 1'b1;
					end else begin
						err_q <= div_quot[31:0];
					end
				end
			end
			lrgd_pkg::S_EMIT: c_q <= c_q + 3'd1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/lrgd_checker.sv
// Port-level checks for the regression block, bound to the top level.
`default_nettype none
module lrgd_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire lrgd_pkg::req_t req,
	input wire logic           busy,
	input wire logic           result_valid,
	input wire lrgd_pkg::res_t result
);
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_weight |=> !busy && !result_valid)
		else $error("run did not end after last weight");

	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_weight |=> result_valid
		&& result.weight_index == $past(result.weight_index) + 3'd1)
		else $error("weight stream broken");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == lrgd_pkg::REQ_LOAD_FEATURE |=> !busy)
		else $error("load transaction made the block busy");
endmodule

bind linear_regression_gradient_descent lrgd_checker u_lrgd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
	.result_valid(result_valid), .result(result)
);
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the gradient-descent regression block: directed and random runs checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int CYCLE_LIMIT    = 4000000;
	localparam int RANDOM_ITEMS   = 330;
	localparam int SETTLE_CYCLES  = 12;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	class regression_scoreboard;
		longint feature_mem [lrgd_pkg::MAX_ROWS*lrgd_pkg::MAX_FEATURES];
		longint target_mem [lrgd_pkg::MAX_ROWS];
		bit     feature_loaded [lrgd_pkg::MAX_ROWS*lrgd_pkg::MAX_FEATURES];
		bit     target_loaded [lrgd_pkg::MAX_ROWS];
		int unsigned row_count_reg;
		int unsigned feature_count_reg;
		int unsigned learning_rate_reg;
		int unsigned iteration_count_reg;
		bit     run_saturated;
		lrgd_pkg::res_t expected_weights[$];
		int     failures;
		int     checked;
		int     runs;

		function new();
			row_count_reg = 1;
			feature_count_reg = 1;
			learning_rate_reg = 655;
			iteration_count_reg = 1000;
			failures = 0;
			checked = 0;
			runs = 0;
			foreach (feature_loaded[i]) feature_loaded[i] = 0;
			foreach (target_loaded[i]) target_loaded[i] = 0;
		endfunction

		function void write_register(logic [2:0] idx, logic [19:0] data);
			case (idx)
				lrgd_pkg::CFG_ROW_COUNT:       row_count_reg = 32'(data[8:0]);
				lrgd_pkg::CFG_FEATURE_COUNT:   feature_count_reg = 32'(data[2:0]);
				lrgd_pkg::CFG_LEARNING_RATE:   learning_rate_reg = 32'(data[15:0]);
				lrgd_pkg::CFG_ITERATION_COUNT: iteration_count_reg = 32'(data);
				default: ;
			endcase
		endfunction

		function int active_rows();
			if (row_count_reg < 1) return 1;
			if (row_count_reg > lrgd_pkg::MAX_ROWS) return lrgd_pkg::MAX_ROWS;
			return row_count_reg;
		endfunction

		function int active_features();
			if (feature_count_reg < 1) return 1;
			if (feature_count_reg > lrgd_pkg::MAX_FEATURES) return lrgd_pkg::MAX_FEATURES;
			return feature_count_reg;
		endfunction

		function int pending();
			return expected_weights.size();
		endfunction

		function longint clamp32(longint x);
			if (x > 64'sd2147483647) begin
				run_saturated = 1;
				return 64'sd2147483647;
			end
			if (x < -64'sd2147483648) begin
				run_saturated = 1;
				return -64'sd2147483648;
			end
			return x;
		endfunction

		function longint to_q16(longint x);
			return (x + 64'sd32768) >>> 16;
		endfunction

		function longint feature_of(int row, int col);
			if (col == 0) return 64'sd65536;
			return feature_mem[row*lrgd_pkg::MAX_FEATURES + col - 1];
		endfunction

		function void train();
			longint w [lrgd_pkg::MAX_FEATURES+1];
			longint grad [lrgd_pkg::MAX_FEATURES+1];
			longint pred, e, avg, delta;
			longint unsigned sse, sq, err;
			int rows, cols, iters;
			lrgd_pkg::res_t r;
			rows = active_rows();
			cols = active_features() + 1;
			iters = (iteration_count_reg < 1) ? 1 : iteration_count_reg;
			run_saturated = 0;
			foreach (w[i]) w[i] = 0;
			sse = 0;
			for (int it = 0; it < iters; it++) begin
				foreach (grad[i]) grad[i] = 0;
				sse = 0;
				for (int row = 0; row < rows; row++) begin
					pred = 0;
					for (int c = 0; c < cols; c++)
						pred += to_q16(w[c] * feature_of(row, c));
					pred = clamp32(pred);
					e = clamp32(pred - target_mem[row]);
					sq = longint'(e * e);
					if (sse > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
						sse = 64'hFFFF_FFFF_FFFF_FFFF;
						run_saturated = 1;
					end else begin
						sse += sq;
					end
					for (int c = 0; c < cols; c++)
						grad[c] += to_q16(e * feature_of(row, c));
				end
				for (int c = 0; c < cols; c++) begin
					avg = grad[c] / longint'(rows);
					delta = to_q16(avg * longint'(learning_rate_reg));
					w[c] = clamp32(w[c] - delta);
				end
			end
			err = sse / (longint'(rows) << 17);
			if (err > 64'hFFFF_FFFF) begin
				err = 64'hFFFF_FFFF;
				run_saturated = 1;
			end
			for (int c = 0; c < cols; c++) begin
				r.weight_index = c[2:0];
				r.weight_value = w[c][31:0];
				r.final_error = err[31:0];
				r.saturated = run_saturated;
				r.last_weight = (c == cols - 1);
				expected_weights.push_back(r);
			end
			runs++;
		endfunction

		function void note_request(lrgd_pkg::req_t item);
			case (item.req_type)
				lrgd_pkg::REQ_LOAD_FEATURE: begin
					if (item.feature_index < lrgd_pkg::MAX_FEATURES) begin
						feature_mem[item.row_index*lrgd_pkg::MAX_FEATURES + item.feature_index] =
							longint'($signed(item.sample_value));
						feature_loaded[item.row_index*lrgd_pkg::MAX_FEATURES
							+ item.feature_index] = 1;
					end
				end
				lrgd_pkg::REQ_LOAD_TARGET: begin
					target_mem[item.row_index] = longint'($signed(item.sample_value));
					target_loaded[item.row_index] = 1;
				end
				lrgd_pkg::REQ_START: train();
				default: ;
			endcase
		endfunction

		function void check_result(lrgd_pkg::res_t got);
			lrgd_pkg::res_t want;
			if (expected_weights.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failures++;
				return;
			end
			want = expected_weights.pop_front();
			checked++;
			if (got.weight_index !== want.weight_index) begin
				$display("%0t: weight_index expected %0d actual %0d", $time,
					want.weight_index, got.weight_index);
				failures++;
			end
			if (got.weight_value !== want.weight_value) begin
				$display("%0t: weight_value expected %h actual %h", $time,
					want.weight_value, got.weight_value);
				failures++;
			end
			if (got.final_error !== want.final_error) begin
				$display("%0t: final_error expected %h actual %h", $time,
					want.final_error, got.final_error);
				failures++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time,
					want.saturated, got.saturated);
				failures++;
			end
			if (got.last_weight !== want.last_weight) begin
				$display("%0t: last_weight expected %b actual %b", $time,
					want.last_weight, got.last_weight);
				failures++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	lrgd_pkg::req_t req_bus;
	logic           busy;
	logic           result_valid;
	lrgd_pkg::res_t result;
	logic           cfg_we;
	logic [2:0]     cfg_index;
	logic [19:0]    cfg_data;

	regression_scoreboard sb;
	int cycle_count;
	int random_sent;
	int total_sent;
	bit burst_mode;

	linear_regression_gradient_descent dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req_bus), .busy(busy),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	function automatic int pick_gap();
		int roll;
		if (burst_mode) return 0;
		roll = $urandom_range(0, 9);
		if (roll < 6) return 0;
		if (roll < 9) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			5: return $urandom;
			6: begin
				case ($urandom_range(0, 2))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					default: return 32'h0;
				endcase
			end
			7: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	task automatic send(input lrgd_pkg::req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req_bus <= item;
		do @(posedge clk); while (busy);
		sb.note_request(item);
		total_sent++;
	endtask

	task automatic send_load(input logic [1:0] kind, input int row, input int col,
			input logic [31:0] value);
		lrgd_pkg::req_t item;
		item.req_type = kind;
		item.row_index = row[7:0];
		item.feature_index = col[2:0];
		item.sample_value = value;
		send(item);
	endtask

	// hold off until the last weight has arrived and the block has settled
	task automatic wait_idle();
		start <= 0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data[19:0];
		@(posedge clk);
		sb.write_register(idx, data[19:0]);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic load_missing();
		for (int row = 0; row < sb.active_rows(); row++) begin
			for (int col = 0; col < sb.active_features(); col++)
				if (!sb.feature_loaded[row*lrgd_pkg::MAX_FEATURES + col])
					send_load(lrgd_pkg::REQ_LOAD_FEATURE, row, col, pick_sample());
			if (!sb.target_loaded[row])
				send_load(lrgd_pkg::REQ_LOAD_TARGET, row, 0, pick_sample());
		end
	endtask

	task automatic start_run();
		lrgd_pkg::req_t item;
		item.req_type = lrgd_pkg::REQ_START;
		item.row_index = 8'($urandom);
		item.feature_index = 3'($urandom);
		item.sample_value = $urandom;
		send(item);
	endtask

	task automatic random_phase();
		int n;
		int sent_before;
		sent_before = total_sent;
		burst_mode = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1))
			write_reg(lrgd_pkg::CFG_ROW_COUNT, ($urandom_range(0, 9) == 0) ?
				$urandom_range(13, 64) : $urandom_range(0, 12));
		if ($urandom_range(0, 1))
			write_reg(lrgd_pkg::CFG_FEATURE_COUNT, $urandom_range(0, 7));
		if ($urandom_range(0, 1))
			write_reg(lrgd_pkg::CFG_LEARNING_RATE, ($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(0, 8000));
		if ($urandom_range(0, 2) == 0)
			write_reg(lrgd_pkg::CFG_ITERATION_COUNT, $urandom_range(0, 5));
		n = $urandom_range(0, 8);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: send_load(REQ_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 7),
					$urandom);
				1: send_load(lrgd_pkg::REQ_LOAD_FEATURE, $urandom_range(0, 255), 7, $urandom);
				2, 3, 4: send_load(lrgd_pkg::REQ_LOAD_TARGET,
					$urandom_range(0, sb.active_rows() - 1), $urandom_range(0, 7),
					pick_sample());
				default: send_load(lrgd_pkg::REQ_LOAD_FEATURE, $urandom_range(0, 255),
					$urandom_range(0, 6), pick_sample());
			endcase
		end
		load_missing();
		start_run();
		if ($urandom_range(0, 4) == 0) start_run();
		random_sent += total_sent - sent_before;
		wait_idle();
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		req_bus = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		random_sent = 0;
		total_sent = 0;
		burst_mode = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// zero row, feature and iteration counts fall back to one; extreme samples saturate
		write_reg(lrgd_pkg::CFG_ROW_COUNT, 0);
		write_reg(lrgd_pkg::CFG_FEATURE_COUNT, 0);
		write_reg(lrgd_pkg::CFG_LEARNING_RATE, 65535);
		write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 0);
		send_load(lrgd_pkg::REQ_LOAD_FEATURE, 0, 0, 32'h7fff_ffff);
		send_load(lrgd_pkg::REQ_LOAD_TARGET, 0, 5, 32'h8000_0000);
		send_load(REQ_UNKNOWN, 0, 0, 32'h1234_5678);
		send_load(lrgd_pkg::REQ_LOAD_FEATURE, 0, 7, 32'hffff_ffff);
		start_run();
		wait_idle();

		// all seven features, zero step, back-to-back runs
		write_reg(lrgd_pkg::CFG_ROW_COUNT, 2);
		write_reg(lrgd_pkg::CFG_FEATURE_COUNT, 7);
		write_reg(lrgd_pkg::CFG_LEARNING_RATE, 0);
		write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 2);
		send_load(lrgd_pkg::REQ_LOAD_FEATURE, 255, 6, 32'h8000_0000);
		send_load(lrgd_pkg::REQ_LOAD_TARGET, 255, 0, 32'h7fff_ffff);
		send_load(lrgd_pkg::REQ_LOAD_FEATURE, 1, 6, 32'h0001_0000);
		load_missing();
		start_run();
		start_run();
		wait_idle();

		// park the largest iteration count, then replace it before any run
		write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 20'hFFFFF);
		send_load(lrgd_pkg::REQ_LOAD_TARGET, 1, 0, 32'h0002_0000);
		wait_idle();
		write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 3);
		write_reg(lrgd_pkg::CFG_LEARNING_RATE, 1);
		write_reg(lrgd_pkg::CFG_ROW_COUNT, 4);
		write_reg(lrgd_pkg::CFG_FEATURE_COUNT, 3);
		load_missing();
		start_run();
		wait_idle();
		write_reg(lrgd_pkg::CFG_ROW_COUNT, 3);
		write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 4);

		while (random_sent < RANDOM_ITEMS) random_phase();

		wait_idle();
		$display("Sent %0d requests over %0d training runs; %0d weight results compared",
			total_sent, sb.runs, sb.checked);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d failures, %0d weight results never arrived", sb.failures,
				sb.pending());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/lrgd_pkg.sv
rtl/lrgd_div.sv
rtl/lrgd_store.sv
rtl/linear_regression_gradient_descent.sv
rtl/lrgd_checker.sv
bench/tb.sv
